>>> rtl/core/vau_pkg.sv
// shared types and constants for the vector arithmetic unit
package vau_pkg;

  localparam int DATA_W      = 32;
  localparam int ACC_W       = 66;
  localparam int SQRT_STAGES = 16;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    OP_ADD       = 3'd0,
    OP_SUB       = 3'd1,
    OP_SCALE     = 3'd2,
    OP_DOT       = 3'd3,
    OP_CROSS     = 3'd4,
    OP_MAGNITUDE = 3'd5,
    OP_NORMALIZE = 3'd6
  } op_t;

  typedef struct packed {
    logic                     vld;
    logic [2:0]               op;
    logic [2:0][DATA_W-1:0]   res;
    logic                     sat;
    logic [2:0][DATA_W-1:0]   a;
  } vau_item_t;

endpackage

>>> rtl/core/vau_front.sv
// products, sums and saturating narrowing for the linear operations
module vau_front import vau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic [2:0]               in_op,
  input  logic signed [DATA_W-1:0] a_i [3],
  input  logic signed [DATA_W-1:0] b_i [3],
  input  logic signed [DATA_W-1:0] k_i,
  output logic [63:0]              sq_o,
  output vau_item_t                item_o
);

  op_t                     op_c;
  logic signed [DATA_W-1:0] ml [6];
  logic signed [DATA_W-1:0] mr [6];
  logic signed [32:0]       sum_nxt [3];

  logic                     s1_vld_r;
  logic [2:0]               s1_op_r;
  logic signed [63:0]       p_r [6];
  logic signed [32:0]       sum_r [3];
  logic [DATA_W-1:0]        a1_r [3];

  logic signed [ACC_W-1:0]  acc_nxt [3];
  logic                     s2_vld_r;
  logic [2:0]               s2_op_r;
  logic signed [ACC_W-1:0]  acc_r [3];
  logic [DATA_W-1:0]        a2_r [3];

  logic signed [ACC_W-1:0]  sh [3];
  logic [2:0]               ovf;
  vau_item_t                item_nxt;
  vau_item_t                item_r;

  assign op_c = op_t'(in_op);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ml[i] = a_i[i];
      case (op_c)
        OP_SCALE: mr[i] = k_i;
        OP_DOT:   mr[i] = b_i[i];
        default:  mr[i] = a_i[i];
      endcase
      ml[i+3] = '0;
      mr[i+3] = '0;
      if (op_c == OP_SUB) begin
        sum_nxt[i] = 33'(a_i[i]) - 33'(b_i[i]);
      end else begin
        sum_nxt[i] = 33'(a_i[i]) + 33'(b_i[i]);
      end
    end
    if (op_c == OP_CROSS) begin
      ml[0] = a_i[1]; mr[0] = b_i[2];
      ml[1] = a_i[2]; mr[1] = b_i[1];
      ml[2] = a_i[2]; mr[2] = b_i[0];
      ml[3] = a_i[0]; mr[3] = b_i[2];
      ml[4] = a_i[0]; mr[4] = b_i[1];
      ml[5] = a_i[1]; mr[5] = b_i[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
    s1_op_r <= in_op;
    for (int i = 0; i < 6; i++) p_r[i] <= ml[i] * mr[i];
    for (int i = 0; i < 3; i++) begin
      sum_r[i] <= sum_nxt[i];
      a1_r[i]  <= a_i[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) acc_nxt[i] = '0;
    case (op_t'(s1_op_r))
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 3; i++) acc_nxt[i] = ACC_W'(sum_r[i]);
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) acc_nxt[i] = ACC_W'(p_r[i]);
      end
      OP_CROSS: begin
        acc_nxt[0] = ACC_W'(p_r[0]) - ACC_W'(p_r[1]);
        acc_nxt[1] = ACC_W'(p_r[2]) - ACC_W'(p_r[3]);
        acc_nxt[2] = ACC_W'(p_r[4]) - ACC_W'(p_r[5]);
      end
      OP_DOT, OP_MAGNITUDE, OP_NORMALIZE: begin
        acc_nxt[0] = ACC_W'(p_r[0]) + ACC_W'(p_r[1]) + ACC_W'(p_r[2]);
      end
      default: begin
        for (int i = 0; i < 3; i++) acc_nxt[i] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_op_r <= s1_op_r;
    for (int i = 0; i < 3; i++) begin
      acc_r[i] <= acc_nxt[i];
      a2_r[i]  <= a1_r[i];
    end
  end

  // sum of squares is never negative and fits 64 bits
  assign sq_o = acc_r[0][63:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (op_t'(s2_op_r) == OP_ADD || op_t'(s2_op_r) == OP_SUB) begin
        sh[i] = acc_r[i];
      end else begin
        sh[i] = acc_r[i] >>> FRAC_BITS;
      end
      ovf[i] = sh[i][ACC_W-1:DATA_W-1] != {(ACC_W-DATA_W+1){sh[i][DATA_W-1]}};
      if (ovf[i]) begin
        item_nxt.res[i] = acc_r[i][ACC_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
        item_nxt.res[i] = sh[i][DATA_W-1:0];
      end
      item_nxt.a[i] = a2_r[i];
    end
    item_nxt.vld = s2_vld_r;
    item_nxt.op  = s2_op_r;
    case (op_t'(s2_op_r))
      OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: item_nxt.sat = |ovf;
      OP_DOT:                             item_nxt.sat = ovf[0];
      default:                            item_nxt.sat = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else begin
      item_r.vld <= item_nxt.vld;
    end
    item_r.op  <= item_nxt.op;
    item_r.res <= item_nxt.res;
    item_r.sat <= item_nxt.sat;
    item_r.a   <= item_nxt.a;
  end

  assign item_o = item_r;

endmodule

>>> rtl/core/vau_sqrt.sv
// pipelined integer square root, two result bits per stage
module vau_sqrt import vau_pkg::*; (
  input  logic        clk,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  localparam int STEPS = 2;
  localparam int RW    = 36;

  logic [RW-1:0] rem_r  [SQRT_STAGES];
  logic [31:0]   root_r [SQRT_STAGES];
  logic [63:0]   rad_r  [SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [31:0]   root_in;
    logic [63:0]   rad_in;
    logic [RW-1:0] rem_nxt;
    logic [31:0]   root_nxt;
    logic [63:0]   rad_nxt;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign rad_in  = rad_r[g-1];
    end

    always_comb begin
      logic [RW-1:0] rv;
      logic [RW-1:0] trial;
      logic [31:0]   qv;
      logic [63:0]   dv;
      rv = rem_in;
      qv = root_in;
      dv = rad_in;
      for (int j = 0; j < STEPS; j++) begin
        rv    = {rv[RW-3:0], dv[63:62]};
        dv    = {dv[61:0], 2'b00};
        trial = {2'b00, qv, 2'b01};
        if (rv >= trial) begin
          rv = rv - trial;
          qv = {qv[30:0], 1'b1};
        end else begin
          qv = {qv[30:0], 1'b0};
        end
      end
      rem_nxt  = rv;
      root_nxt = qv;
      rad_nxt  = dv;
    end

    always_ff @(posedge clk) begin
      rem_r[g]  <= rem_nxt;
      root_r[g] <= root_nxt;
      rad_r[g]  <= rad_nxt;
    end
  end

  assign root = root_r[SQRT_STAGES-1];

endmodule

>>> rtl/core/vau_div.sv
// pipelined restoring divider for one normalized component
module vau_div import vau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic signed [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0]        divisor,
  output logic signed [DATA_W-1:0] quotient
);

  localparam int STAGES = (FRAC_BITS + 2) / 2;
  localparam int NB     = 2 * STAGES;
  localparam int DW     = DATA_W + FRAC_BITS;
  localparam int RW     = 35;
  localparam int STEPS  = 2;

  logic [DATA_W-1:0] mag;
  logic [DW-1:0]     dvd;

  logic [RW-1:0]     rem_r  [STAGES];
  logic [NB-1:0]     bits_r [STAGES];
  logic [NB-1:0]     quo_r  [STAGES];
  logic [DATA_W-1:0] den_r  [STAGES];
  logic              neg_r  [STAGES];
  logic [DATA_W-1:0] q_mag;

  assign mag = dividend[DATA_W-1] ? (~dividend + 32'd1) : dividend;
  assign dvd = {mag, {FRAC_BITS{1'b0}}};

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [RW-1:0]     rem_in;
    logic [NB-1:0]     bits_in;
    logic [NB-1:0]     quo_in;
    logic [DATA_W-1:0] den_in;
    logic              neg_in;
    logic [RW-1:0]     rem_nxt;
    logic [NB-1:0]     bits_nxt;
    logic [NB-1:0]     quo_nxt;

    if (g == 0) begin : g_first
      // upper dividend bits are already below the divisor
      assign rem_in  = RW'(dvd[DW-1:NB]);
      assign bits_in = dvd[NB-1:0];
      assign quo_in  = '0;
      assign den_in  = divisor;
      assign neg_in  = dividend[DATA_W-1];
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign bits_in = bits_r[g-1];
      assign quo_in  = quo_r[g-1];
      assign den_in  = den_r[g-1];
      assign neg_in  = neg_r[g-1];
    end

    always_comb begin
      logic [RW-1:0] rv;
      logic [NB-1:0] bv;
      logic [NB-1:0] qv;
      rv = rem_in;
      bv = bits_in;
      qv = quo_in;
      for (int j = 0; j < STEPS; j++) begin
        rv = {rv[RW-2:0], bv[NB-1]};
        bv = {bv[NB-2:0], 1'b0};
        if (rv >= RW'(den_in)) begin
          rv = rv - RW'(den_in);
          qv = {qv[NB-2:0], 1'b1};
        end else begin
          qv = {qv[NB-2:0], 1'b0};
        end
      end
      rem_nxt  = rv;
      bits_nxt = bv;
      quo_nxt  = qv;
    end

    always_ff @(posedge clk) begin
      rem_r[g]  <= rem_nxt;
      bits_r[g] <= bits_nxt;
      quo_r[g]  <= quo_nxt;
      den_r[g]  <= den_in;
      neg_r[g]  <= neg_in;
    end
  end

  assign q_mag    = DATA_W'(quo_r[STAGES-1]);
  assign quotient = neg_r[STAGES-1] ? -q_mag : q_mag;

endmodule

>>> rtl/core/vector3_arith_unit.sv
// top level of the q-format 3d vector arithmetic unit
//
// a transaction is taken at a rising edge with start high and busy low; busy
// stays low, so one transaction can be taken in every cycle. in_operation
// selects add, subtract, scale, dot, cross, magnitude or normalize on vectors
// a and b (and in_scale_factor for scale).
// every transaction returns exactly one result, in order, on the out_ ports
// for one cycle with out_valid high; the receiver cannot stall.
// all operations share one pipeline depth. it is set by the square root
// pipeline (16 stages, two root bits each) followed by the divider pipeline
// ((FRAC_BITS+2)/2 stages, two quotient bits each), plus two multiply/sum
// stages and the output register.
// throughput is one transaction per cycle.
// reset clears only the valid bits in flight; no result comes out for
// transactions taken before reset.
module vector3_arith_unit import vau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_operation,
  input  logic signed [DATA_W-1:0] in_a_x,
  input  logic signed [DATA_W-1:0] in_a_y,
  input  logic signed [DATA_W-1:0] in_a_z,
  input  logic signed [DATA_W-1:0] in_b_x,
  input  logic signed [DATA_W-1:0] in_b_y,
  input  logic signed [DATA_W-1:0] in_b_z,
  input  logic signed [DATA_W-1:0] in_scale_factor,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_res_x,
  output logic signed [DATA_W-1:0] out_res_y,
  output logic signed [DATA_W-1:0] out_res_z,
  output logic signed [DATA_W-1:0] out_res_scalar,
  output logic                     out_saturated,
  output logic                     out_zero_divide
);

  localparam int DIV_STAGES = (FRAC_BITS + 2) / 2;
  localparam int LINE_LEN   = SQRT_STAGES - 1 + DIV_STAGES;
  localparam int DIV_TAP    = SQRT_STAGES - 2;

  logic signed [DATA_W-1:0] a_v [3];
  logic signed [DATA_W-1:0] b_v [3];
  logic [63:0]              sq;
  logic [DATA_W-1:0]        root;
  logic signed [DATA_W-1:0] quo [3];
  vau_item_t                front_item;
  vau_item_t                line_nxt [LINE_LEN];
  vau_item_t                line_r [LINE_LEN];
  logic [DATA_W-1:0]        root_r [DIV_STAGES];
  vau_item_t                fin;
  logic [DATA_W-1:0]        rt;

  logic                     valid_nxt;
  logic [DATA_W-1:0]        x_nxt, y_nxt, z_nxt, s_nxt;
  logic                     sat_nxt, zdiv_nxt;
  logic                     valid_r;
  logic [DATA_W-1:0]        x_r, y_r, z_r, s_r;
  logic                     sat_r, zdiv_r;

  assign busy = 1'b0;

  assign a_v[0] = in_a_x;
  assign a_v[1] = in_a_y;
  assign a_v[2] = in_a_z;
  assign b_v[0] = in_b_x;
  assign b_v[1] = in_b_y;
  assign b_v[2] = in_b_z;

  vau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (start & ~busy),
    .in_op  (in_operation),
    .a_i    (a_v),
    .b_i    (b_v),
    .k_i    (in_scale_factor),
    .sq_o   (sq),
    .item_o (front_item)
  );

  vau_sqrt u_sqrt (
    .clk      (clk),
    .radicand (sq),
    .root     (root)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    vau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk      (clk),
      .dividend ($signed(line_r[DIV_TAP].a[i])),
      .divisor  (root),
      .quotient (quo[i])
    );
  end

  // delay line keeps each transaction aligned with its root and quotients
  always_comb begin
    line_nxt[0] = front_item;
    for (int k = 1; k < LINE_LEN; k++) line_nxt[k] = line_r[k-1];
    if (!rst_n) begin
      for (int k = 0; k < LINE_LEN; k++) line_nxt[k].vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LINE_LEN; k++) line_r[k] <= line_nxt[k];
    root_r[0] <= root;
    for (int k = 1; k < DIV_STAGES; k++) root_r[k] <= root_r[k-1];
  end

  assign fin = line_r[LINE_LEN-1];
  assign rt  = root_r[DIV_STAGES-1];

  always_comb begin
    valid_nxt = fin.vld;
    x_nxt     = '0;
    y_nxt     = '0;
    z_nxt     = '0;
    s_nxt     = '0;
    sat_nxt   = 1'b0;
    zdiv_nxt  = 1'b0;
    case (op_t'(fin.op))
      OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: begin
        x_nxt   = fin.res[0];
        y_nxt   = fin.res[1];
        z_nxt   = fin.res[2];
        sat_nxt = fin.sat;
      end
      OP_DOT: begin
        s_nxt   = fin.res[0];
        sat_nxt = fin.sat;
      end
      OP_MAGNITUDE: begin
        sat_nxt = rt[DATA_W-1];
        s_nxt   = rt[DATA_W-1] ? SAT_MAX : rt;
      end
      OP_NORMALIZE: begin
        if (rt == '0) begin
          zdiv_nxt = 1'b1;
        end else begin
          x_nxt = quo[0];
          y_nxt = quo[1];
          z_nxt = quo[2];
        end
      end
      default: begin
        x_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    s_r    <= s_nxt;
    sat_r  <= sat_nxt;
    zdiv_r <= zdiv_nxt;
  end

  assign out_valid       = valid_r;
  assign out_res_x       = x_r;
  assign out_res_y       = y_r;
  assign out_res_z       = z_r;
  assign out_res_scalar  = s_r;
  assign out_saturated   = sat_r;
  assign out_zero_divide = zdiv_r;

endmodule
